// ===== hw/rtl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
`default_nettype none
package salc_pkg;

    // Block address width kept as the tag (offset is at least 2 bits)
    localparam int TAG_W = 30;

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_IFETCH = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS     = 2'd0;
    localparam logic [1:0] CFG_SET_COUNT       = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE     = 2'd2;
    localparam logic [1:0] CFG_WORDS_PER_BLOCK = 2'd3;

    // Statistics counter slots
    localparam int CNT_INST_ACC  = 0;
    localparam int CNT_INST_MISS = 1;
    localparam int CNT_INST_REPL = 2;
    localparam int CNT_DATA_ACC  = 3;
    localparam int CNT_DATA_MISS = 4;
    localparam int CNT_DATA_REPL = 5;
    localparam int CNT_FETCH     = 6;
    localparam int CNT_COPYBACK  = 7;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  operation;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        wrote_back;
        logic [31:0] inst_accesses;
        logic [31:0] inst_misses;
        logic [31:0] inst_replacements;
        logic [31:0] data_accesses;
        logic [31:0] data_misses;
        logic [31:0] data_replacements;
        logic [31:0] fetch_words;
        logic [31:0] copyback_words;
    } t_rsp;

endpackage
`default_nettype wire

// ===== hw/rtl/salc_setmod.sv =====
// Bit-serial remainder unit: set index = tag mod set count.
`default_nettype none
module salc_setmod #(
    parameter int MAX_SETS = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [salc_pkg::TAG_W-1:0]           i_tag,
    input  wire logic [$clog2(MAX_SETS+1)-1:0]        i_sets,
    output logic                                      o_done,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] o_rem
);
    import salc_pkg::*;

    localparam int REM_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SW    = $clog2(MAX_SETS + 1);
    localparam int CNT_W = $clog2(TAG_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TAG_W-1:0] r_q, n_q;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [SW-1:0]    r_sets, n_sets;
    logic [REM_W:0]   shifted;
    logic [REM_W:0]   sets_x;

    // One quotient bit per cycle, restoring form
    always_comb begin
        shifted = {r_rem, r_q[TAG_W-1]};
        sets_x  = (REM_W + 1)'(r_sets);
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_sets  = r_sets;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(TAG_W);
            n_q    = i_tag;
            n_rem  = '0;
            n_sets = i_sets;
        end else if (r_busy) begin
            if (shifted >= sets_x) begin
                n_rem = REM_W'(shifted - sets_x);
            end else begin
                n_rem = REM_W'(shifted);
            end
            n_q   = {r_q[TAG_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_sets <= n_sets;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ===== hw/rtl/set_assoc_lru_cache_model.sv =====
// Access: set-index remainder, tag scan (read and check per way), a decide step,
// recency update per way in use, a response step, strobe in the next cycle.
// Flush: a read and a write step per line over MAX_SETS*MAX_WAYS lines, then respond.
// One item at a time; o_busy is high from accept until the result strobe.
// After reset a clear sweep writes every line, with busy high.
// o_done pulses one cycle with the result; the receiver cannot stall.
`default_nettype none
module set_assoc_lru_cache_model #(
    parameter int MAX_SETS     = 256,
    parameter int MAX_WAYS     = 8,
    parameter int COUNTER_BITS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire salc_pkg::t_req  i_item,
    output logic                 o_busy,
    output logic                 o_done,
    output salc_pkg::t_rsp       o_result,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [10:0]     i_cfg_data
);
    import salc_pkg::*;

    localparam int LINES  = MAX_SETS * MAX_WAYS;
    localparam int IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int REM_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SW     = $clog2(MAX_SETS + 1);
    localparam int WIX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int RANK_W = WIX_W;
    localparam int LIM_W  = WCNT_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              valid;
        logic              dirty;
        logic [RANK_W-1:0] rank;
    } t_line;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_DEC   = 10'b0000100000,
        S_UPD   = 10'b0001000000,
        S_FL_RD = 10'b0010000000,
        S_FL_WR = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } t_state;

    function automatic logic [COUNTER_BITS-1:0] sat_add(
        input logic [COUNTER_BITS-1:0] c,
        input logic [10:0]             amt
    );
        logic [COUNTER_BITS:0] s;
        s = {1'b0, c} + (COUNTER_BITS + 1)'(amt);
        return s[COUNTER_BITS] ? CNT_MAX : s[COUNTER_BITS-1:0];
    endfunction

    // Configuration registers, raw
    logic [3:0]  r_cfg_ob;
    logic [8:0]  r_cfg_sets;
    logic [3:0]  r_cfg_ways;
    logic [10:0] r_cfg_wpb;

    // Clamped configuration
    logic [3:0]        ob_c;
    logic [SW-1:0]     sets_c;
    logic [WCNT_W-1:0] ways_c;
    logic [10:0]       wpb_c;

    always_comb begin
        ob_c = (r_cfg_ob < 4'd2) ? 4'd2 : ((r_cfg_ob > 4'd12) ? 4'd12 : r_cfg_ob);
        if (r_cfg_sets == 9'd0) begin
            sets_c = SW'(1);
        end else if (32'(r_cfg_sets) > 32'(MAX_SETS)) begin
            sets_c = SW'(MAX_SETS);
        end else begin
            sets_c = SW'(r_cfg_sets);
        end
        if (r_cfg_ways == 4'd0) begin
            ways_c = WCNT_W'(1);
        end else if (32'(r_cfg_ways) > 32'(MAX_WAYS)) begin
            ways_c = WCNT_W'(MAX_WAYS);
        end else begin
            ways_c = WCNT_W'(r_cfg_ways);
        end
        if (r_cfg_wpb == 11'd0) begin
            wpb_c = 11'd1;
        end else if (r_cfg_wpb > 11'd1024) begin
            wpb_c = 11'd1024;
        end else begin
            wpb_c = r_cfg_wpb;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ob   <= 4'd4;
            r_cfg_sets <= 9'd256;
            r_cfg_ways <= 4'd1;
            r_cfg_wpb  <= 11'd4;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_BITS:     r_cfg_ob   <= i_cfg_data[3:0];
                CFG_SET_COUNT:       r_cfg_sets <= i_cfg_data[8:0];
                CFG_WAYS_IN_USE:     r_cfg_ways <= i_cfg_data[3:0];
                CFG_WORDS_PER_BLOCK: r_cfg_wpb  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line store
    t_line             r_mem [LINES];
    t_line             r_rdata;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    t_line             mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Sequencer state
    t_state            r_state, n_state;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic              r_store, n_store;
    logic              r_inst, n_inst;
    logic [IDX_W-1:0]  r_base, n_base;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WCNT_W-1:0] r_w, n_w;
    t_line             r_way [MAX_WAYS];
    logic              way_we;
    logic              r_found_ok, n_found_ok;
    logic [WIX_W-1:0]  r_found, n_found;
    logic              r_free_ok, n_free_ok;
    logic [WIX_W-1:0]  r_free, n_free;
    logic              r_vic_ok, n_vic_ok;
    logic [WIX_W-1:0]  r_vic, n_vic;
    logic [RANK_W-1:0] r_vrank, n_vrank;
    logic [WIX_W-1:0]  r_tgt, n_tgt;
    logic [LIM_W-1:0]  r_limit, n_limit;
    logic              r_hit, n_hit;
    logic              r_evict, n_evict;
    logic              r_wb, n_wb;
    logic [COUNTER_BITS-1:0] r_cnt [8];
    logic [COUNTER_BITS-1:0] n_cnt [8];
    logic              r_done, n_done;
    t_rsp              r_res, n_res;

    logic              accept;
    logic [31:0]       shifted_addr;
    logic [TAG_W-1:0]  tag_in;
    logic              div_done;
    logic [REM_W-1:0]  div_rem;
    t_line             cur, upd;
    logic [WIX_W-1:0]  w_ix;

    assign accept       = i_start && (r_state == S_IDLE);
    assign shifted_addr = i_item.address >> ob_c;
    assign tag_in       = shifted_addr[TAG_W-1:0];
    assign w_ix         = r_w[WIX_W-1:0];

    salc_setmod #(
        .MAX_SETS (MAX_SETS)
    ) u_setmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_item.operation != OP_FLUSH)),
        .i_tag   (tag_in),
        .i_sets  (sets_c),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    always_comb begin
        n_state    = r_state;
        n_tag      = r_tag;
        n_store    = r_store;
        n_inst     = r_inst;
        n_base     = r_base;
        n_idx      = r_idx;
        n_w        = r_w;
        n_found_ok = r_found_ok;
        n_found    = r_found;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_vic_ok   = r_vic_ok;
        n_vic      = r_vic;
        n_vrank    = r_vrank;
        n_tgt      = r_tgt;
        n_limit    = r_limit;
        n_hit      = r_hit;
        n_evict    = r_evict;
        n_wb       = r_wb;
        n_cnt      = r_cnt;
        n_done     = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_raddr  = r_idx;
        way_we     = 1'b0;
        cur        = r_way[w_ix];
        upd        = cur;

        case (r_state)
            // Post-reset sweep: every line invalid
            S_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_W'(LINES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_hit   = 1'b0;
                    n_evict = 1'b0;
                    n_wb    = 1'b0;
                    n_idx   = '0;
                    n_tag   = tag_in;
                    n_store = (i_item.operation == OP_STORE);
                    n_inst  = (i_item.operation == OP_IFETCH);
                    if (i_item.operation == OP_FLUSH) begin
                        n_state = S_FL_RD;
                    end else begin
                        if (i_item.operation == OP_IFETCH) begin
                            n_cnt[CNT_INST_ACC] = sat_add(r_cnt[CNT_INST_ACC], 11'd1);
                        end else begin
                            n_cnt[CNT_DATA_ACC] = sat_add(r_cnt[CNT_DATA_ACC], 11'd1);
                        end
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_base     = IDX_W'(32'(div_rem) * MAX_WAYS);
                    n_w        = '0;
                    n_found_ok = 1'b0;
                    n_free_ok  = 1'b0;
                    n_vic_ok   = 1'b0;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                mem_raddr = r_base + IDX_W'(r_w);
                n_state   = S_CHK;
            end
            // Tag match, first free way, highest-ranked victim
            S_CHK: begin
                way_we = 1'b1;
                if (r_rdata.valid) begin
                    if (!r_found_ok && (r_rdata.tag == r_tag)) begin
                        n_found_ok = 1'b1;
                        n_found    = w_ix;
                    end
                    if (!r_vic_ok || (r_rdata.rank > r_vrank)) begin
                        n_vic_ok = 1'b1;
                        n_vic    = w_ix;
                        n_vrank  = r_rdata.rank;
                    end
                end else if (!r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = w_ix;
                end
                n_w = r_w + 1'b1;
                if (r_w == ways_c - 1'b1) begin
                    n_state = S_DEC;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DEC: begin
                n_w = '0;
                if (r_found_ok) begin
                    n_hit   = 1'b1;
                    n_tgt   = r_found;
                    n_limit = LIM_W'(r_way[r_found].rank);
                end else begin
                    if (r_inst) begin
                        n_cnt[CNT_INST_MISS] = sat_add(r_cnt[CNT_INST_MISS], 11'd1);
                    end else begin
                        n_cnt[CNT_DATA_MISS] = sat_add(r_cnt[CNT_DATA_MISS], 11'd1);
                    end
                    n_cnt[CNT_FETCH] = sat_add(r_cnt[CNT_FETCH], wpb_c);
                    if (r_free_ok) begin
                        n_tgt   = r_free;
                        n_limit = LIM_W'(MAX_WAYS);
                    end else begin
                        n_tgt   = r_vic;
                        n_limit = LIM_W'(r_way[r_vic].rank);
                        n_evict = 1'b1;
                        if (r_inst) begin
                            n_cnt[CNT_INST_REPL] = sat_add(r_cnt[CNT_INST_REPL], 11'd1);
                        end else begin
                            n_cnt[CNT_DATA_REPL] = sat_add(r_cnt[CNT_DATA_REPL], 11'd1);
                        end
                        if (r_way[r_vic].dirty) begin
                            n_wb = 1'b1;
                            n_cnt[CNT_COPYBACK] = sat_add(r_cnt[CNT_COPYBACK], wpb_c);
                        end
                    end
                end
                n_state = S_UPD;
            end
            // Age younger lines, install or promote the target way
            S_UPD: begin
                if (cur.valid && (LIM_W'(cur.rank) < r_limit)
                        && (32'(cur.rank) < MAX_WAYS - 1)) begin
                    upd.rank = cur.rank + 1'b1;
                end
                if (w_ix == r_tgt) begin
                    if (r_hit) begin
                        upd.rank  = '0;
                        upd.dirty = cur.dirty | r_store;
                    end else begin
                        upd.tag   = r_tag;
                        upd.valid = 1'b1;
                        upd.dirty = r_store;
                        upd.rank  = '0;
                    end
                end
                mem_we    = 1'b1;
                mem_waddr = r_base + IDX_W'(r_w);
                mem_wdata = upd;
                n_w       = r_w + 1'b1;
                if (r_w == ways_c - 1'b1) begin
                    n_state = S_RESP;
                end
            end
            S_FL_RD: begin
                n_state = S_FL_WR;
            end
            // Count dirty lines, invalidate
            S_FL_WR: begin
                if (r_rdata.valid && r_rdata.dirty) begin
                    n_wb = 1'b1;
                    n_cnt[CNT_COPYBACK] = sat_add(r_cnt[CNT_COPYBACK], wpb_c);
                end
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_W'(LINES - 1)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_RESP: begin
                n_done                  = 1'b1;
                n_res.hit               = r_hit;
                n_res.evicted           = r_evict;
                n_res.wrote_back        = r_wb;
                n_res.inst_accesses     = 32'(r_cnt[CNT_INST_ACC]);
                n_res.inst_misses       = 32'(r_cnt[CNT_INST_MISS]);
                n_res.inst_replacements = 32'(r_cnt[CNT_INST_REPL]);
                n_res.data_accesses     = 32'(r_cnt[CNT_DATA_ACC]);
                n_res.data_misses       = 32'(r_cnt[CNT_DATA_MISS]);
                n_res.data_replacements = 32'(r_cnt[CNT_DATA_REPL]);
                n_res.fetch_words       = 32'(r_cnt[CNT_FETCH]);
                n_res.copyback_words    = 32'(r_cnt[CNT_COPYBACK]);
                n_state                 = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_tag      <= n_tag;
        r_store    <= n_store;
        r_inst     <= n_inst;
        r_base     <= n_base;
        r_w        <= n_w;
        r_found_ok <= n_found_ok;
        r_found    <= n_found;
        r_free_ok  <= n_free_ok;
        r_free     <= n_free;
        r_vic_ok   <= n_vic_ok;
        r_vic      <= n_vic;
        r_vrank    <= n_vrank;
        r_tgt      <= n_tgt;
        r_limit    <= n_limit;
        r_hit      <= n_hit;
        r_evict    <= n_evict;
        r_wb       <= n_wb;
        r_res      <= n_res;
        if (way_we) begin
            r_way[w_ix] <= r_rdata;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the set-associative LRU write-back cache model.
`default_nettype none
module testbench;
    import salc_pkg::*;

    localparam int N_SETS  = 256;
    localparam int N_WAYS  = 8;
    localparam int N_LINES = N_SETS * N_WAYS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    t_req        req = '0;
    logic        busy;
    logic        done;
    t_rsp        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;

    set_assoc_lru_cache_model i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_item      (req),
        .o_busy      (busy),
        .o_done      (done),
        .o_result    (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the cache state and configuration
    logic [3:0]  m_offset;
    logic [8:0]  m_sets;
    logic [3:0]  m_ways;
    logic [10:0] m_wpb;
    logic [31:0] m_tag   [N_LINES];
    logic        m_valid [N_LINES];
    logic        m_dirty [N_LINES];
    logic [2:0]  m_rank  [N_LINES];
    logic [31:0] m_cnt   [8];

    t_req accesses_pending[$];
    t_rsp expected_rsp[$];

    int  sender_idle_pct = 24;
    int  mismatches = 0;

    function automatic void cnt_add(int slot, int unsigned amount);
        longint unsigned s;
        s = longint'(m_cnt[slot]) + amount;
        m_cnt[slot] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void age_ways(int base, int ways, int limit);
        for (int w = 0; w < ways; w++)
            if (m_valid[base+w] && m_rank[base+w] < limit && m_rank[base+w] < N_WAYS - 1)
                m_rank[base+w]++;
    endfunction

    // Cache access prediction, producing one expected result
    function automatic t_rsp cache_access(t_req a);
        int ob, sets, ways, wpb, base, found, freew, victim, vrank, k;
        logic [31:0] tag;
        bit inst, store;
        t_rsp r;
        ob = (m_offset < 2) ? 2 : (m_offset > 12 ? 12 : m_offset);
        sets = (m_sets < 1) ? 1 : (m_sets > N_SETS ? N_SETS : m_sets);
        ways = (m_ways < 1) ? 1 : (m_ways > N_WAYS ? N_WAYS : m_ways);
        wpb = (m_wpb < 1) ? 1 : (m_wpb > 1024 ? 1024 : m_wpb);
        r = '0;
        if (a.operation == OP_FLUSH) begin
            for (int i = 0; i < N_LINES; i++) begin
                if (m_valid[i] && m_dirty[i]) begin
                    cnt_add(CNT_COPYBACK, wpb);
                    r.wrote_back = 1'b1;
                end
                m_valid[i] = 1'b0;
                m_dirty[i] = 1'b0;
                m_rank[i] = '0;
            end
        end else begin
            tag = a.address >> ob;
            base = (tag % sets) * N_WAYS;
            inst = (a.operation == OP_IFETCH);
            store = (a.operation == OP_STORE);
            found = ways;
            freew = ways;
            victim = 0;
            vrank = -1;
            cnt_add(inst ? CNT_INST_ACC : CNT_DATA_ACC, 1);
            for (int w = 0; w < ways; w++) begin
                if (m_valid[base+w]) begin
                    if (found == ways && m_tag[base+w] == tag) found = w;
                    if (int'(m_rank[base+w]) > vrank) begin
                        vrank = m_rank[base+w];
                        victim = w;
                    end
                end else if (freew == ways) begin
                    freew = w;
                end
            end
            if (found < ways) begin
                k = base + found;
                r.hit = 1'b1;
                age_ways(base, ways, m_rank[k]);
                m_rank[k] = '0;
                if (store) m_dirty[k] = 1'b1;
            end else begin
                cnt_add(inst ? CNT_INST_MISS : CNT_DATA_MISS, 1);
                cnt_add(CNT_FETCH, wpb);
                if (freew < ways) begin
                    k = base + freew;
                    age_ways(base, ways, N_WAYS);
                end else begin
                    k = base + victim;
                    r.evicted = 1'b1;
                    cnt_add(inst ? CNT_INST_REPL : CNT_DATA_REPL, 1);
                    if (m_dirty[k]) begin
                        r.wrote_back = 1'b1;
                        cnt_add(CNT_COPYBACK, wpb);
                    end
                    age_ways(base, ways, m_rank[k]);
                end
                m_tag[k] = tag;
                m_valid[k] = 1'b1;
                m_dirty[k] = store;
                m_rank[k] = '0;
            end
        end
        r.inst_accesses     = m_cnt[CNT_INST_ACC];
        r.inst_misses       = m_cnt[CNT_INST_MISS];
        r.inst_replacements = m_cnt[CNT_INST_REPL];
        r.data_accesses     = m_cnt[CNT_DATA_ACC];
        r.data_misses       = m_cnt[CNT_DATA_MISS];
        r.data_replacements = m_cnt[CNT_DATA_REPL];
        r.fetch_words       = m_cnt[CNT_FETCH];
        r.copyback_words    = m_cnt[CNT_COPYBACK];
        return r;
    endfunction

    // Driver: start held until accepted, random gaps between items
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                expected_rsp.push_back(cache_access(req));
                void'(accesses_pending.pop_front());
            end
            if ((start && !busy) || !start) begin
                if (accesses_pending.size() > 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    req <= accesses_pending[0];
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && done) begin
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", rsp);
            end else begin
                e = expected_rsp.pop_front();
                if (rsp !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h actual %h", e, rsp);
                end
            end
        end
    end

    task automatic wait_drained();
        while (accesses_pending.size() != 0 || start || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_OFFSET_BITS:     m_offset = val[3:0];
            CFG_SET_COUNT:       m_sets = val[8:0];
            CFG_WAYS_IN_USE:     m_ways = val[3:0];
            default:             m_wpb = val;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_access(logic [31:0] addr, logic [1:0] op);
        t_req a;
        a.address = addr;
        a.operation = op;
        accesses_pending.push_back(a);
    endtask

    // Random traffic, mostly reuse of a small address pool for hits and conflicts
    task automatic random_phase(int n);
        logic [31:0] pool[16];
        logic [1:0]  op;
        foreach (pool[i]) pool[i] = $urandom();
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(99) < 2) ? OP_FLUSH : 2'($urandom_range(2));
            case ($urandom_range(3))
                0: push_access($urandom(), op);
                default: push_access(pool[$urandom_range(15)] ^ $urandom_range(3), op);
            endcase
        end
    endtask

    // Stimulus
    initial begin
        m_offset = 4; m_sets = 256; m_ways = 1; m_wpb = 4;
        for (int i = 0; i < N_LINES; i++) begin
            m_tag[i] = '0; m_valid[i] = 0; m_dirty[i] = 0; m_rank[i] = '0;
        end
        foreach (m_cnt[i]) m_cnt[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);

        // Directed: reset settings, extremes, every operation, conflicts, flush
        push_access(32'h0000_0000, OP_LOAD);
        push_access(32'hFFFF_FFFF, OP_STORE);
        push_access(32'h0000_0000, OP_IFETCH);
        push_access(32'h0000_1000, OP_LOAD);
        push_access(32'h0000_0000, OP_STORE);
        push_access(32'h0001_0000, OP_LOAD);
        push_access(32'hAAAA_5555, OP_IFETCH);
        push_access(32'h5555_AAAA, OP_STORE);
        push_access(32'h0000_0000, OP_FLUSH);
        push_access(32'hFFFF_FFFF, OP_FLUSH);
        wait_drained();

        // Out-of-range values clamp; small sets, many ways to force LRU eviction
        write_reg(CFG_OFFSET_BITS, 11'd15);
        write_reg(CFG_SET_COUNT, 11'd0);
        write_reg(CFG_WAYS_IN_USE, 11'd15);
        write_reg(CFG_WORDS_PER_BLOCK, 11'd2047);
        for (int i = 0; i < 10; i++) push_access(32'(i) << 12, OP_STORE);
        push_access(32'h0, OP_LOAD);
        push_access(32'h0000_9000, OP_IFETCH);
        wait_drained();
        write_reg(CFG_WAYS_IN_USE, 11'd2);
        push_access(32'h0000_5000, OP_LOAD);
        push_access(32'h0000_F000, OP_STORE);
        push_access(32'h0, OP_FLUSH);
        wait_drained();

        // Random phases across settings and idling profiles
        for (int ph = 0; ph < 6; ph++) begin
            sender_idle_pct = (ph < 2) ? 24 : (ph < 4 ? 49 : 0);
            write_reg(CFG_OFFSET_BITS, (ph == 0) ? 11'd2 : (ph == 1 ? 11'd12 :
                      11'($urandom_range(15))));
            write_reg(CFG_SET_COUNT, (ph == 2) ? 11'd256 : (ph == 3 ? 11'd1 :
                      11'($urandom_range(511))));
            write_reg(CFG_WAYS_IN_USE, (ph == 4) ? 11'd8 : 11'($urandom_range(15)));
            write_reg(CFG_WORDS_PER_BLOCK, (ph == 5) ? 11'd1024 : 11'($urandom_range(2047)));
            random_phase(315);
            wait_drained();
        end

        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Timeout: flushes, which visit every line, dominate the run time
    initial begin
        #400_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/salc_pkg.sv
hw/rtl/salc_setmod.sv
hw/rtl/set_assoc_lru_cache_model.sv
test/testbench.sv
